FILE: design/utcs_pkg.sv
// Shared types, field widths and calendar helpers for the UTC to local time shifter.
// Used by utcs_time_wrap, utcs_date_roll and utc_to_local_calendar_shift.
// No dependencies.
package utcs_pkg;

    localparam int YEAR_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int TZ_W     = 12;
    localparam int TOD_W    = 11;  // minute of day, 0..1439
    localparam int TOTAL_W  = 13;  // signed minute of day before the wrap

    localparam int MIN_PER_DAY  = 1440;
    localparam int MIN_PER_HOUR = 60;
    localparam int TZ_LIMIT     = 1439;

    // Reciprocal of 60 scaled by 2^16, exact for every minute of day.
    localparam int RECIP_60       = 1093;
    localparam int RECIP_60_SHIFT = 16;

    // Inverse of 25 modulo 2^16; y is a multiple of 25 when y * INV_25 stays
    // at or below the largest 16-bit multiple count.
    localparam logic [YEAR_W-1:0] INV_25     = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX  = 16'd2621;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] BAD_MONTH_DAYS = 5'd30;
    localparam logic [DAY_W-1:0] LEAP_FEB_DAYS  = 5'd29;

    localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Whole days crossed by the time of day: -1, 0, +1 or +2.
    typedef logic signed [2:0] day_shift_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Gregorian leap year: divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = year * INV_25;
        div25 = (prod <= DIV25_MAX);
        return ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);
    endfunction

    // Days in a month; a month code outside 1..12 counts as 30 days.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic               leap);
        logic [DAY_W-1:0] len;
        if (month < MONTH_JAN || month > MONTH_DEC) begin
            len = BAD_MONTH_DAYS;
        end else if (month == MONTH_FEB && leap) begin
            len = LEAP_FEB_DAYS;
        end else begin
            len = MONTH_DAYS[month - MONTH_JAN];
        end
        return len;
    endfunction

endpackage

FILE: design/utcs_time_wrap.sv
// Time-of-day path: adds the saturated offset, wraps over the day and splits hour/minute.
// Depends on utcs_pkg.
module utcs_time_wrap
    import utcs_pkg::*;
(
    input  logic [HOUR_W-1:0]          hour_in,
    input  logic [MINUTE_W-1:0]        minute_in,
    input  logic signed [TZ_W-1:0]     tz_offset,
    output logic [HOUR_W-1:0]          hour_out,
    output logic [MINUTE_W-1:0]        minute_out,
    output day_shift_t                 shift
);

    logic signed [TZ_W-1:0]    off;
    logic [TOD_W-1:0]          hour_x60;
    logic signed [TOTAL_W-1:0] total;
    logic [TOD_W-1:0]          tod;
    logic [2*TOD_W-1:0]        prod;
    logic [HOUR_W-1:0]         quot;
    logic [TOD_W-1:0]          quot_x60;

    always_comb begin
        if (tz_offset > TZ_W'(TZ_LIMIT)) begin
            off = TZ_W'(TZ_LIMIT);
        end else if (tz_offset < -TZ_W'(TZ_LIMIT)) begin
            off = -TZ_W'(TZ_LIMIT);
        end else begin
            off = tz_offset;
        end
    end

    // hour * 60 as (hour << 6) - (hour << 2)
    assign hour_x60 = {hour_in, 6'b0} - {4'b0, hour_in, 2'b0};

    assign total = $signed({2'b00, hour_x60})
                 + $signed({{(TOTAL_W-MINUTE_W){1'b0}}, minute_in})
                 + $signed({off[TZ_W-1], off});

    always_comb begin
        if (total < 0) begin
            tod   = TOD_W'(total + TOTAL_W'(MIN_PER_DAY));
            shift = -3'sd1;
        end else if (total >= TOTAL_W'(2 * MIN_PER_DAY)) begin
            tod   = TOD_W'(total - TOTAL_W'(2 * MIN_PER_DAY));
            shift = 3'sd2;
        end else if (total >= TOTAL_W'(MIN_PER_DAY)) begin
            tod   = TOD_W'(total - TOTAL_W'(MIN_PER_DAY));
            shift = 3'sd1;
        end else begin
            tod   = total[TOD_W-1:0];
            shift = 3'sd0;
        end
    end

    assign prod       = (2*TOD_W)'(tod) * (2*TOD_W)'(RECIP_60);
    assign quot       = prod[RECIP_60_SHIFT +: HOUR_W];
    assign quot_x60   = {quot, 6'b0} - {4'b0, quot, 2'b0};
    assign hour_out   = quot;
    assign minute_out = MINUTE_W'(tod - quot_x60);

endmodule

FILE: design/utcs_date_roll.sv
// Date path: applies a day shift to year, month and day with Gregorian month lengths.
// Depends on utcs_pkg.
module utcs_date_roll
    import utcs_pkg::*;
(
    input  date_t      date_in,
    input  day_shift_t shift,
    output date_t      date_out
);

    logic signed [DAY_W+1:0] day_sum;
    logic                    leap;
    logic [MONTH_W-1:0]      month_prev;
    logic [DAY_W-1:0]        len_cur;
    logic [DAY_W-1:0]        len_prev;
    logic                    wrap_back;
    logic                    wrap_fwd;

    assign day_sum    = $signed({2'b00, date_in.day}) + $signed({{4{shift[2]}}, shift});
    assign leap       = is_leap(date_in.year);
    assign wrap_back  = (date_in.month <= MONTH_JAN);
    assign wrap_fwd   = (date_in.month >= MONTH_DEC);
    assign month_prev = wrap_back ? MONTH_DEC : date_in.month - MONTH_W'(1);
    // February is only reached backward from March, so the year is unchanged there.
    assign len_cur    = month_days(date_in.month, leap);
    assign len_prev   = month_days(month_prev, leap);

    always_comb begin
        date_out = date_in;
        if (shift != 3'sd0) begin
            if (day_sum < 1) begin
                date_out.month = month_prev;
                date_out.year  = wrap_back ? date_in.year - YEAR_W'(1) : date_in.year;
                date_out.day   = DAY_W'(day_sum + $signed({2'b00, len_prev}));
            end else if (day_sum > $signed({2'b00, len_cur})) begin
                date_out.month = wrap_fwd ? MONTH_JAN : date_in.month + MONTH_W'(1);
                date_out.year  = wrap_fwd ? date_in.year + YEAR_W'(1) : date_in.year;
                date_out.day   = DAY_W'(day_sum - $signed({2'b00, len_cur}));
            end else begin
                date_out.day   = day_sum[DAY_W-1:0];
            end
        end
    end

endmodule

FILE: design/utc_to_local_calendar_shift.sv
// Top level of the UTC to local calendar shifter: input register, shift logic, result register.
// Depends on utcs_pkg, utcs_time_wrap and utcs_date_roll.
//
// Each item carries one UTC timestamp and a validity flag; the block adds the signed timezone
// offset held in the configuration register (minutes, saturated to +/-1439 when used), wraps
// the time of day over 1440 minutes and rolls day, month and year by the days crossed, using
// Gregorian leap years, with the year wrapping modulo 65536. Seconds pass through. An item whose
// validity flag is clear yields a result of all zeros. The block takes one item per cycle
// sustained while the result side does not stall; an item is held first in the input register,
// then in the result register, and all shift logic sits between those two registers. A stall
// on the result side propagates back through s_tready in the same cycle, so a held result
// never blocks acceptance while the input register is empty. The offset register is written
// through cfg_we/cfg_wdata and should only change while no item is in flight.
module utc_to_local_calendar_shift
    import utcs_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_we,
    input  logic [TZ_W-1:0]        cfg_wdata,    // tz_offset_minutes, two's complement

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // year[15:0], month[19:16], day[24:20], hour[29:25],
    // minute[35:30], second[41:36], zero fill [47:42]
    input  logic [47:0]            s_tdata,
    input  logic                   s_tuser,      // timestamp known flag

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // local_year[15:0], local_month[19:16], local_day[24:20], local_hour[29:25],
    // local_minute[35:30], local_second[41:36], zero fill [47:42]
    output logic [47:0]            m_tdata,
    output logic                   m_tuser       // local_valid
);

    // Configuration register.
    logic signed [TZ_W-1:0] tz_reg;

    // Input register stage.
    logic                   in_valid_reg;
    logic                   in_ok_reg;
    date_t                  in_date_reg;
    logic [HOUR_W-1:0]      in_hour_reg;
    logic [MINUTE_W-1:0]    in_minute_reg;
    logic [SECOND_W-1:0]    in_second_reg;

    // Result register stage.
    logic                   out_valid_reg;
    logic                   out_ok_reg;
    date_t                  out_date_reg;
    logic [HOUR_W-1:0]      out_hour_reg;
    logic [MINUTE_W-1:0]    out_minute_reg;
    logic [SECOND_W-1:0]    out_second_reg;

    logic                   out_ok_next;
    date_t                  out_date_next;
    logic [HOUR_W-1:0]      out_hour_next;
    logic [MINUTE_W-1:0]    out_minute_next;
    logic [SECOND_W-1:0]    out_second_next;

    date_t                  rolled_date;
    logic [HOUR_W-1:0]      local_hour;
    logic [MINUTE_W-1:0]    local_minute;
    day_shift_t             shift;
    logic                   advance;

    // The result register can take a new item when it is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    utcs_time_wrap u_time_wrap (
        .hour_in    (in_hour_reg),
        .minute_in  (in_minute_reg),
        .tz_offset  (tz_reg),
        .hour_out   (local_hour),
        .minute_out (local_minute),
        .shift      (shift)
    );

    utcs_date_roll u_date_roll (
        .date_in  (in_date_reg),
        .shift    (shift),
        .date_out (rolled_date)
    );

    // An invalid timestamp produces an all-zero result.
    always_comb begin
        out_ok_next     = in_ok_reg;
        out_date_next   = '0;
        out_hour_next   = '0;
        out_minute_next = '0;
        out_second_next = '0;
        if (in_ok_reg) begin
            out_date_next   = rolled_date;
            out_hour_next   = local_hour;
            out_minute_next = local_minute;
            out_second_next = in_second_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tz_reg        <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                tz_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_ok_reg         <= s_tuser;
            in_date_reg.year  <= s_tdata[15:0];
            in_date_reg.month <= s_tdata[19:16];
            in_date_reg.day   <= s_tdata[24:20];
            in_hour_reg       <= s_tdata[29:25];
            in_minute_reg     <= s_tdata[35:30];
            in_second_reg     <= s_tdata[41:36];
        end
        if (advance && in_valid_reg) begin
            out_ok_reg     <= out_ok_next;
            out_date_reg   <= out_date_next;
            out_hour_reg   <= out_hour_next;
            out_minute_reg <= out_minute_next;
            out_second_reg <= out_second_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {6'b0, out_second_reg, out_minute_reg, out_hour_reg,
                       out_date_reg.day, out_date_reg.month, out_date_reg.year};

endmodule

FILE: verif/local_time_checker.sv
`timescale 1ns / 100ps
// Checker for utc_to_local_calendar_shift: follows the offset register and both item channels,
// predicts every local timestamp and compares each result with the oldest prediction.
// Depends on utcs_pkg for field widths and calendar constants.
module local_time_checker
    import utcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [TZ_W-1:0]   cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [47:0]       m_tdata,
    input  logic              m_tuser,
    output int                mismatch_count,
    output int                in_flight
);

    localparam int FIRST_MONTH   = 1;
    localparam int LAST_MONTH    = 12;
    localparam int FEBRUARY      = 2;
    localparam int ODD_MONTH_LEN = 30;

    typedef struct packed {
        logic                valid;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } local_time_t;

    logic signed [TZ_W-1:0] tz_offset;
    local_time_t            expected_local_q [$];
    int                     result_count = 0;

    function automatic bit leap_year(input logic [YEAR_W-1:0] yr);
        int y;
        y = int'(yr);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // A month number outside the calendar counts as thirty days.
    function automatic int month_length(input logic [YEAR_W-1:0] yr, input int mon);
        int len;
        if (mon < FIRST_MONTH || mon > LAST_MONTH) begin
            len = ODD_MONTH_LEN;
        end else if (mon == FEBRUARY) begin
            len = leap_year(yr) ? 29 : 28;
        end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            len = 30;
        end else begin
            len = 31;
        end
        return len;
    endfunction

    function automatic local_time_t utc_to_local(input logic valid, input logic [47:0] utc,
                                                 input logic signed [TZ_W-1:0] tz);
        local_time_t       loc;
        logic [YEAR_W-1:0] yr;
        int                mon;
        int                dd;
        int                off;
        int                tod;
        int                shift;
        loc = '0;
        if (valid) begin
            yr  = utc[15:0];
            mon = int'(utc[19:16]);
            dd  = int'(utc[24:20]);
            off = int'(tz);
            if (off > TZ_LIMIT) begin
                off = TZ_LIMIT;
            end else if (off < -TZ_LIMIT) begin
                off = -TZ_LIMIT;
            end
            tod   = int'(utc[29:25]) * MIN_PER_HOUR + int'(utc[35:30]) + off;
            shift = 0;
            while (tod < 0) begin
                tod += MIN_PER_DAY;
                shift--;
            end
            while (tod >= MIN_PER_DAY) begin
                tod -= MIN_PER_DAY;
                shift++;
            end
            // Without a day shift the date goes through untouched, even when malformed.
            if (shift != 0) begin
                dd += shift;
                while (dd < 1) begin
                    mon--;
                    if (mon < FIRST_MONTH) begin
                        mon = LAST_MONTH;
                        yr  = yr - YEAR_W'(1);
                    end
                    dd += month_length(yr, mon);
                end
                while (dd > month_length(yr, mon)) begin
                    dd -= month_length(yr, mon);
                    mon++;
                    if (mon > LAST_MONTH) begin
                        mon = FIRST_MONTH;
                        yr  = yr + YEAR_W'(1);
                    end
                end
            end
            loc.valid  = 1'b1;
            loc.year   = yr;
            loc.month  = mon[MONTH_W-1:0];
            loc.day    = dd[DAY_W-1:0];
            loc.hour   = HOUR_W'(tod / MIN_PER_HOUR);
            loc.minute = MINUTE_W'(tod % MIN_PER_HOUR);
            loc.second = utc[41:36];
        end
        return loc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: result %0d: %s", $time, result_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [YEAR_W-1:0] got,
                               input logic [YEAR_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        local_time_t want;
        if (!aresetn) begin
            tz_offset <= '0;
            expected_local_q.delete();
            in_flight <= 0;
        end else begin
            if (cfg_we) begin
                tz_offset <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                expected_local_q.push_back(utc_to_local(s_tuser, s_tdata, tz_offset));
            end
            if (m_tvalid && m_tready) begin
                if (expected_local_q.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_local_q.pop_front();
                    check_field("local_valid", m_tuser, want.valid);
                    check_field("local_year", m_tdata[15:0], want.year);
                    check_field("local_month", m_tdata[19:16], want.month);
                    check_field("local_day", m_tdata[24:20], want.day);
                    check_field("local_hour", m_tdata[29:25], want.hour);
                    check_field("local_minute", m_tdata[35:30], want.minute);
                    check_field("local_second", m_tdata[41:36], want.second);
                    check_field("zero fill", m_tdata[47:42], '0);
                end
                result_count++;
            end
            in_flight <= expected_local_q.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for utc_to_local_calendar_shift: clock, reset, offset register writes,
// timestamp stimulus, receiver stalls, watchdog and the final verdict.
// Depends on utcs_pkg, utc_to_local_calendar_shift and local_time_checker.
module tb_top;
    import utcs_pkg::*;

    // A run only fails on a timeout when nothing at all moves for this many cycles.
    localparam int WATCHDOG_LIMIT  = 2000;
    // Length of the deliberate receiver hold-off that backs the block up.
    localparam int LONG_HOLD       = 64;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 100;
    // The block holds at most two items, so a few cycles cover any straggler.
    localparam int TAIL_CYCLES     = 10;
    localparam int RESET_CYCLES    = 11;

    typedef struct packed {
        logic                valid;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } utc_item_t;

    logic            aclk;
    logic            aresetn;
    logic            cfg_we;
    logic [TZ_W-1:0] cfg_wdata;
    logic            s_tvalid;
    logic            s_tready;
    logic [47:0]     s_tdata;
    logic            s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [47:0]     m_tdata;
    logic            m_tuser;

    int mismatch_count;
    int in_flight;

    // Percentage of cycles in which the receiver refuses a result.
    int stall_pct   = 0;
    // The stimulus asks for a long hold-off by bumping hold_ask; the receiver
    // answers each request once and records it in hold_done.
    int hold_ask    = 0;
    int hold_done   = 0;
    int idle_cycles = 0;
    // Saturated offset in force, used only to aim items close to local midnight.
    int tz_now      = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    utc_to_local_calendar_shift dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    local_time_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .in_flight      (in_flight)
    );

    function automatic utc_item_t utc(input logic v, input logic [YEAR_W-1:0] y,
                                      input logic [MONTH_W-1:0] mo, input logic [DAY_W-1:0] d,
                                      input logic [HOUR_W-1:0] h, input logic [MINUTE_W-1:0] mi,
                                      input logic [SECOND_W-1:0] s);
        utc_item_t it;
        it.valid  = v;
        it.year   = y;
        it.month  = mo;
        it.day    = d;
        it.hour   = h;
        it.minute = mi;
        it.second = s;
        return it;
    endfunction

    // Most random items are plausible timestamps, many of them placed so that the
    // offset carries them across local midnight on a month or year boundary. The
    // rest is raw noise over every bit of every field, valid or not.
    function automatic utc_item_t random_utc();
        utc_item_t it;
        int        kind;
        int        target;
        int        utc_min;
        kind      = $urandom_range(0, 99);
        it.valid  = 1'b1;
        it.year   = YEAR_W'($urandom);
        it.month  = MONTH_W'($urandom);
        it.day    = DAY_W'($urandom);
        it.hour   = HOUR_W'($urandom);
        it.minute = MINUTE_W'($urandom);
        it.second = SECOND_W'($urandom);
        if (kind < 8) begin
            it.valid = 1'b0;
        end else if (kind >= 20) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 7))
                        0:       it.year = '0;
                        1:       it.year = '1;
                        2:       it.year = 16'd1900;
                        3:       it.year = 16'd2000;
                        4:       it.year = 16'd2100;
                        5:       it.year = 16'd2400;
                        6:       it.year = 16'd2024;
                        default: it.year = YEAR_W'($urandom_range(0, 655) * 100);
                    endcase
                end
                1: begin
                    it.year = YEAR_W'($urandom_range(0, 16383) * 4);
                end
                default: begin
                    it.year = YEAR_W'($urandom);
                end
            endcase
            it.month = MONTH_W'($urandom_range(1, 12));
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0:       it.day = 5'd1;
                    1:       it.day = 5'd28;
                    2:       it.day = 5'd29;
                    3:       it.day = 5'd30;
                    default: it.day = 5'd31;
                endcase
            end else begin
                it.day = DAY_W'($urandom_range(1, 28));
            end
            if ($urandom_range(0, 99) < 60) begin
                if ($urandom_range(0, 1) == 1) begin
                    target = int'($urandom_range(0, 3));
                end else begin
                    target = MIN_PER_DAY - 1 - int'($urandom_range(0, 3));
                end
                utc_min   = ((target - tz_now) % MIN_PER_DAY + MIN_PER_DAY) % MIN_PER_DAY;
                it.hour   = HOUR_W'(utc_min / MIN_PER_HOUR);
                it.minute = MINUTE_W'(utc_min % MIN_PER_HOUR);
            end else begin
                it.hour   = HOUR_W'($urandom_range(0, 23));
                it.minute = MINUTE_W'($urandom_range(0, 59));
            end
            it.second = SECOND_W'($urandom_range(0, 60));
        end
        return it;
    endfunction

    // Offers one item, after a random number of idle cycles, and returns at the clock
    // edge where the block takes it. tvalid is left high; the next call or the drain
    // decides what it does in the following cycle.
    task automatic send_item(input utc_item_t it, input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.valid;
        s_tdata  <= {6'b0, it.second, it.minute, it.hour, it.day, it.month, it.year};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Stops offering items and waits until every expected result has been taken.
    // The first edge lets the checker count an item accepted in this very cycle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) begin
            @(posedge aclk);
        end
    endtask

    // The offset only changes while the block is empty.
    task automatic write_offset(input logic [TZ_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tz_now     = int'(signed'(value));
        if (tz_now > TZ_LIMIT) begin
            tz_now = TZ_LIMIT;
        end else if (tz_now < -TZ_LIMIT) begin
            tz_now = -TZ_LIMIT;
        end
    endtask

    // Hand-picked timestamps, sent once with the largest positive offset and once
    // with the largest negative one, so that each crosses midnight in some run.
    task automatic send_directed();
        utc_item_t list [$];
        // Invalid item with every field at its maximum: the result must be all zeros.
        list.push_back(utc(1'b0, '1, '1, '1, '1, '1, '1));
        // Last minute of the last year: rolls the year over to zero.
        list.push_back(utc(1'b1, '1, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60));
        // First minute of year zero: rolls back to the last year.
        list.push_back(utc(1'b1, '0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
        // Centuries: 2000 is a leap year, 1900 is not.
        list.push_back(utc(1'b1, 16'd2000, 4'd2, 5'd28, 5'd23, 6'd0, 6'd1));
        list.push_back(utc(1'b1, 16'd1900, 4'd2, 5'd28, 5'd23, 6'd0, 6'd2));
        // Stepping back from the first of March into a leap and a common February.
        list.push_back(utc(1'b1, 16'd2024, 4'd3, 5'd1, 5'd0, 6'd30, 6'd3));
        list.push_back(utc(1'b1, 16'd2023, 4'd3, 5'd1, 5'd0, 6'd30, 6'd4));
        // Malformed date: passes through when the day does not change, else rolls back
        // into month fourteen, counted as thirty days.
        list.push_back(utc(1'b1, 16'd2023, 4'd15, 5'd0, 5'd0, 6'd0, 6'd5));
        // Month zero on a forward roll.
        list.push_back(utc(1'b1, 16'd2023, 4'd0, 5'd31, 5'd23, 6'd59, 6'd6));
        // Hour and minute beyond range: with the largest offset this is two days on.
        list.push_back(utc(1'b1, 16'd2023, 4'd2, 5'd31, 5'd31, 6'd63, 6'd7));
        // Month thirteen, stepping back.
        list.push_back(utc(1'b1, 16'd2023, 4'd13, 5'd30, 5'd0, 6'd0, 6'd8));
        list.push_back(utc(1'b1, 16'd2100, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59));
        // All-zero valid timestamp, day zero stepping back into December.
        list.push_back(utc(1'b1, '0, '0, '0, '0, '0, 6'd63));
        foreach (list[k]) begin
            send_item(list[k], 0);
        end
    endtask

    // Receiver: random stalls at the rate of the current phase, plus a long hold-off
    // whenever the stimulus asks for one, during which the sender keeps offering.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_ask != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = hold_done + 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int offsets [PHASES];
        int idle_pct;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        idle_pct   = 0;

        // One offset per random phase: zero, both limits, values the register holds
        // but that saturate when used, ordinary zones and one fully random pattern.
        offsets     = '{0, TZ_LIMIT, -TZ_LIMIT, 2047, -2048, 1440, -1440, 0, 330, -480, -1, 0};
        offsets[7]  = int'($urandom_range(0, 2 * TZ_LIMIT)) - TZ_LIMIT;
        offsets[11] = int'($urandom_range(0, 4095)) - 2048;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        write_offset(TZ_W'(TZ_LIMIT));
        send_directed();
        write_offset(TZ_W'(-TZ_LIMIT));
        send_directed();

        // Idling rotates through the phases: none, sender idle, receiver stalling,
        // then both sides at a lower rate.
        for (int p = 0; p < PHASES; p++) begin
            write_offset(TZ_W'(offsets[p]));
            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 59;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 59;
                end
                default: begin
                    idle_pct  = 27;
                    stall_pct = 27;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // In phases 4 and 8, which have no idling, back the block up so that it stalls its input.
                if ((p == 4 || p == 8) && n == 20) begin
                    hold_ask = hold_ask + 1;
                end
                send_item(random_utc(), idle_pct);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
